FILE: sv/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Shared widths, payload types and the ASCII offset; no dependencies.
`timescale 1ns / 1ps

package b2da_pkg;

  // Fixed payload widths
  localparam int VALUE_W = 32;  // binary input width, one chain stage per bit
  localparam int BCD_W   = 4;   // bits per decimal digit
  localparam int CHAR_W  = 6;   // width of one emitted character

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [BCD_W-1:0]   bcd_digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // ASCII '0', truncated to the character width
  localparam char_t ASCII_ZERO = 6'h30;

  // Double-dabble correction threshold and offset
  localparam bcd_digit_t DD_THRESH = 4'd5;
  localparam bcd_digit_t DD_ADJUST = 4'd3;

endpackage : b2da_pkg

FILE: sv/b2da_if.sv
// Valid/ready channel interfaces for the converter's input and result sides.
// Depends on b2da_pkg for the payload types.
`timescale 1ns / 1ps

// Input channel: one binary number per transfer
interface b2da_in_if import b2da_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : b2da_in_if

// Result channel: one ASCII digit per transfer
interface b2da_out_if import b2da_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t digit_char;
  logic  last_char;

  modport source (output valid, output digit_char, output last_char, input ready);
  modport sink   (input valid, input digit_char, input last_char, output ready);
endinterface : b2da_out_if

FILE: sv/b2da_digit_cell.sv
// One BCD digit cell of a double-dabble stage: add-3 correction, shift by one.
// Depends on b2da_pkg. The carry chains to the next higher digit's cell.
`timescale 1ns / 1ps

module b2da_digit_cell import b2da_pkg::*; (
  input  logic       clk,
  input  logic       adv,       // stage advance
  input  bcd_digit_t digit_in,  // same digit from the previous stage
  input  logic       carry_in,  // bit shifted in from the lower digit
  output logic       carry_out, // bit shifted out to the higher digit
  output bcd_digit_t digit_out
);

  bcd_digit_t adj;
  bcd_digit_t digit_r;
  bcd_digit_t digit_nxt;

  // Correct digits of five or more, then shift left one place
  always_comb begin
    adj       = (digit_in >= DD_THRESH) ? digit_in + DD_ADJUST : digit_in;
    carry_out = adj[BCD_W-1];
    digit_nxt = {adj[BCD_W-2:0], carry_in};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit_out = digit_r;

endmodule : b2da_digit_cell

FILE: sv/b2da_stage.sv
// One step of the conversion chain: a row of digit cells plus the binary
// remainder and a valid bit. Depends on b2da_pkg and b2da_digit_cell.
`timescale 1ns / 1ps

module b2da_stage import b2da_pkg::*; #(
  parameter int DIGIT_COUNT = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              valid_in,
  input  value_t                            bin_in,
  input  logic [DIGIT_COUNT-1:0][BCD_W-1:0] bcd_in,
  output logic                              valid_out,
  output value_t                            bin_out,
  output logic [DIGIT_COUNT-1:0][BCD_W-1:0] bcd_out
);

  logic   valid_r;
  value_t bin_r;
  logic [DIGIT_COUNT:0] carry;

  // Binary msb feeds the lowest digit
  assign carry[0] = bin_in[VALUE_W-1];

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
    b2da_digit_cell u_cell (
      .clk       (clk),
      .adv       (adv),
      .digit_in  (bcd_in[g]),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1]),
      .digit_out (bcd_out[g])
    );
  end

  // Carry out of the top digit is dropped: digits kept modulo 10^DIGIT_COUNT
  logic unused_top_carry;
  assign unused_top_carry = carry[DIGIT_COUNT];

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  // Binary remainder shifts out msb first
  always_ff @(posedge clk) begin
    if (adv) begin
      bin_r <= {bin_in[VALUE_W-2:0], 1'b0};
    end
  end

  assign valid_out = valid_r;
  assign bin_out   = bin_r;

endmodule : b2da_stage

FILE: sv/b2da_emit.sv
// Character serializer: takes a finished BCD word, skips leading zeros and
// sends one ASCII digit per transfer. Depends on b2da_pkg and b2da_out_if.
`timescale 1ns / 1ps

module b2da_emit import b2da_pkg::*; #(
  parameter int DIGIT_COUNT = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              bcd_valid,
  input  logic [DIGIT_COUNT-1:0][BCD_W-1:0] bcd_in,
  output logic                              load,      // BCD word taken
  b2da_out_if.source                        out_chan
);

  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic                              active_r;
  logic [IDX_W-1:0]                  idx_r;
  logic [IDX_W-1:0]                  top_idx;
  logic [DIGIT_COUNT-1:0][BCD_W-1:0] digits_r;
  logic                              last_xfer;

  // Highest nonzero digit; zero value points at the units digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd_in[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign last_xfer = active_r && out_chan.ready && (idx_r == '0);
  assign load      = bcd_valid && (!active_r || last_xfer);

  // Serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (load) begin
      active_r <= 1'b1;
    end else if (last_xfer) begin
      active_r <= 1'b0;
    end
  end

  // Digit store and index
  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= bcd_in;
      idx_r    <= top_idx;
    end else if (active_r && out_chan.ready) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  assign out_chan.valid      = active_r;
  assign out_chan.digit_char = ASCII_ZERO + CHAR_W'(digits_r[idx_r]);
  assign out_chan.last_char  = (idx_r == '0);

endmodule : b2da_emit

FILE: sv/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter with leading-zero blanking.
// Depends on b2da_pkg, b2da_if, b2da_stage and b2da_emit.
//
//   channel   dir  signals                                  carries
//   in_chan   in   valid, ready, value[31:0]                one unsigned number
//   out_chan  out  valid, ready, digit_char[5:0], last_char one ASCII digit
//
// A 32-stage double-dabble chain (one stage per input bit) takes a new
// number in any cycle in which it advances. The serializer then sends one
// character per cycle while out_chan.ready is high, 1 to 10 characters per
// number, one per shown digit, and loads the next number as its last goes out.
// Reset clears only the valid bits. When out_chan.ready is low the chain
// stops once its last stage holds a word, and in_chan.ready follows.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top import b2da_pkg::*; #(
  parameter int DIGIT_COUNT = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  b2da_in_if.sink    in_chan,
  b2da_out_if.source out_chan
);

  logic                              adv;
  logic                              load;
  logic                              valid_s [VALUE_W+1];
  value_t                            bin_s   [VALUE_W+1];
  logic [DIGIT_COUNT-1:0][BCD_W-1:0] bcd_s   [VALUE_W+1];

  // Chain advances unless its last stage holds a word the serializer won't take
  assign adv           = !valid_s[VALUE_W] || load;
  assign in_chan.ready = adv;

  // Chain input
  assign valid_s[0] = in_chan.valid;
  assign bin_s[0]   = in_chan.value;
  assign bcd_s[0]   = '0;

  for (genvar s = 0; s < VALUE_W; s++) begin : g_stage
    b2da_stage #(
      .DIGIT_COUNT (DIGIT_COUNT)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (valid_s[s]),
      .bin_in    (bin_s[s]),
      .bcd_in    (bcd_s[s]),
      .valid_out (valid_s[s+1]),
      .bin_out   (bin_s[s+1]),
      .bcd_out   (bcd_s[s+1])
    );
  end

  // All binary bits are consumed by the last stage
  value_t unused_bin;
  assign unused_bin = bin_s[VALUE_W];

  b2da_emit #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .bcd_valid (valid_s[VALUE_W]),
    .bcd_in    (bcd_s[VALUE_W]),
    .load      (load),
    .out_chan  (out_chan)
  );

endmodule : binary_to_decimal_ascii_top
